@@ rtl/ssag_pkg.sv @@
// ssag_pkg: payload structs, status and command codes, microcode format and program
// for the spaced sample acquisition gate. Depends on nothing.
package ssag_pkg;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_ADD     = 1'b1;

  localparam logic [15:0] MIN_DIST_RESET = 16'd70;
  localparam logic [31:0] LIMIT_RESET    = 32'(MIN_DIST_RESET) * 32'(MIN_DIST_RESET);
  localparam int          NEAR_W         = 35;
  localparam logic [NEAR_W-1:0] NEAR_ALL = '1;

  typedef enum logic [1:0] {
    ST_STORED   = 2'd0,
    ST_DISCARD  = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_RESTART  = 2'd3
  } status_e;

  typedef struct packed {
    logic        command;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } in_t;

  typedef struct packed {
    status_e           status;
    logic [6:0]        stored_count;
    logic [NEAR_W-1:0] nearest_squared;
  } out_t;

  // microcode
  localparam int PC_W        = 3;
  localparam int UCODE_DEPTH = 8;

  typedef enum logic [2:0] {
    C_ALWAYS   = 3'd0,
    C_NO_IN    = 3'd1,
    C_RESTART  = 3'd2,
    C_MORE     = 3'd3,
    C_BUSY     = 3'd4,
    C_OUT_FULL = 3'd5
  } cond_e;

  typedef struct packed {
    logic take;
    logic init;
    logic scan;
    logic decide;
    logic restart;
  } act_t;

  typedef struct packed {
    cond_e           cond;
    logic [PC_W-1:0] target;
    act_t            act;
  } ctl_t;

  localparam logic [PC_W-1:0] P_FETCH    = 3'd0;
  localparam logic [PC_W-1:0] P_DISPATCH = 3'd1;
  localparam logic [PC_W-1:0] P_SCAN     = 3'd2;
  localparam logic [PC_W-1:0] P_DRAIN    = 3'd3;
  localparam logic [PC_W-1:0] P_DECIDE   = 3'd4;
  localparam logic [PC_W-1:0] P_RESTART  = 3'd6;

  localparam act_t A_NONE    = '{take: 1'b0, init: 1'b0, scan: 1'b0, decide: 1'b0, restart: 1'b0};
  localparam act_t A_TAKE    = '{take: 1'b1, init: 1'b0, scan: 1'b0, decide: 1'b0, restart: 1'b0};
  localparam act_t A_INIT    = '{take: 1'b0, init: 1'b1, scan: 1'b0, decide: 1'b0, restart: 1'b0};
  localparam act_t A_SCAN    = '{take: 1'b0, init: 1'b0, scan: 1'b1, decide: 1'b0, restart: 1'b0};
  localparam act_t A_DECIDE  = '{take: 1'b0, init: 1'b0, scan: 1'b0, decide: 1'b1, restart: 1'b0};
  localparam act_t A_RESTART = '{take: 1'b0, init: 1'b0, scan: 1'b0, decide: 1'b0, restart: 1'b1};

  // jump to target when the condition holds, else fall through
  localparam ctl_t UCODE [UCODE_DEPTH] = '{
    '{cond: C_NO_IN,    target: P_FETCH,    act: A_TAKE},
    '{cond: C_RESTART,  target: P_RESTART,  act: A_INIT},
    '{cond: C_MORE,     target: P_SCAN,     act: A_SCAN},
    '{cond: C_BUSY,     target: P_DRAIN,    act: A_NONE},
    '{cond: C_OUT_FULL, target: P_DECIDE,   act: A_DECIDE},
    '{cond: C_ALWAYS,   target: P_FETCH,    act: A_NONE},
    '{cond: C_OUT_FULL, target: P_RESTART,  act: A_RESTART},
    '{cond: C_ALWAYS,   target: P_FETCH,    act: A_NONE}
  };

endpackage

@@ rtl/ssag_dist.sv @@
// ssag_dist: three-stage pipelined squared distance between a sample and a stored entry.
// Stages: axis difference magnitude, square, sum. No package dependency.
module ssag_dist #(
  parameter int AXIS_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic [2:0][AXIS_BITS-1:0]    smp_i,
  input  logic [2:0][AXIS_BITS-1:0]    ent_i,
  output logic                         vld_o,
  output logic                         busy_o,
  output logic [2*AXIS_BITS+1:0]       dist_o
);

  localparam int SQW = 2 * AXIS_BITS;
  localparam int DW  = SQW + 2;

  logic [2:0] vld_q;
  logic [AXIS_BITS-1:0] mag_d [3];
  logic [AXIS_BITS-1:0] mag_q [3];
  logic [SQW-1:0]       sq_q  [3];
  logic [DW-1:0]        sum_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [AXIS_BITS:0] diff;
      logic        [AXIS_BITS:0] neg;
      diff = $signed({ent_i[a][AXIS_BITS-1], ent_i[a]})
           - $signed({smp_i[a][AXIS_BITS-1], smp_i[a]});
      neg  = -diff;
      mag_d[a] = diff[AXIS_BITS] ? neg[AXIS_BITS-1:0] : diff[AXIS_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      mag_q[a] <= mag_d[a];
      sq_q[a]  <= SQW'(mag_q[a]) * SQW'(mag_q[a]);
    end
    sum_q <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
  end

  assign vld_o  = vld_q[2];
  assign busy_o = |vld_q;
  assign dist_o = sum_q;

endmodule

@@ rtl/spaced_sample_acquisition_gate.sv @@
// spaced_sample_acquisition_gate: microcoded sequencer over ssag_pkg and ssag_dist.
// Items are handled one at a time; an add scans the n samples stored in the current group
// (at most GROUP_SIZE - 1), one memory read per cycle, through the read register and the
// ssag_dist stages. The next item is taken only after the result of the last is registered,
// which waits while the output is stalled.
// Reset clears the count and the sequencer; min_distance returns to 70; memory is not cleared.
module spaced_sample_acquisition_gate #(
  parameter int GROUP_SIZE = 30,
  parameter int GROUPS     = 3,
  parameter int AXIS_BITS  = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ssag_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ssag_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [15:0]    cfg_data_i
);

  localparam int SLOTS = GROUP_SIZE * GROUPS;
  localparam int CNTW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DW    = 2 * AXIS_BITS + 2;
  localparam int RW    = (AXIS_BITS > 16) ? AXIS_BITS : 16;
  localparam int LW    = (DW > 32) ? DW : 32;
  localparam int EW    = (DW > ssag_pkg::NEAR_W) ? DW : ssag_pkg::NEAR_W;
  localparam int XW    = (CNTW > 7) ? CNTW : 7;

  function automatic logic [AXIS_BITS-1:0] axis_val(input logic [15:0] raw);
    logic [RW-1:0] w;
    w = RW'(raw);
    return w[AXIS_BITS-1:0];
  endfunction

  // sequencer
  logic [ssag_pkg::PC_W-1:0] pc_q, pc_d;
  ssag_pkg::ctl_t            ctl;
  logic                      cond_true;

  logic                         cmd_q;
  logic [2:0][AXIS_BITS-1:0]    smp_q;
  logic [CNTW-1:0]              cnt_q, cnt_d, base_q, base_d, idx_q;
  logic [31:0]                  limit_q;
  logic [DW-1:0]                near_q;
  logic                         found_q;
  logic                         out_valid_q;
  ssag_pkg::out_t               out_q;

  logic [2:0][AXIS_BITS-1:0]    mem [SLOTS];
  logic [2:0][AXIS_BITS-1:0]    rd_data_q;
  logic                         rd_vld_q;
  logic                         rd_en;

  logic                         d_vld, d_busy, busy;
  logic [DW-1:0]                d_val;

  logic in_fire, out_full, do_dec, do_rst, keep, last, sat;
  logic [EW-1:0]                near_ext;
  logic [ssag_pkg::NEAR_W-1:0]  near_field;
  logic [XW-1:0]                cnt_wide;
  ssag_pkg::status_e            status;

  assign ctl        = ssag_pkg::UCODE[pc_q];
  assign in_fire    = in_valid_i & ctl.act.take;
  assign in_stall_o = ~ctl.act.take;
  assign out_full   = out_valid_q & out_stall_i;
  assign busy       = rd_vld_q | d_busy;
  assign rd_en      = ctl.act.scan & (idx_q < cnt_q);
  assign do_dec     = ctl.act.decide & ~out_full;
  assign do_rst     = ctl.act.restart & ~out_full;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    unique case (ctl.cond)
      ssag_pkg::C_ALWAYS:   cond_true = 1'b1;
      ssag_pkg::C_NO_IN:    cond_true = ~in_fire;
      ssag_pkg::C_RESTART:  cond_true = (cmd_q == ssag_pkg::CMD_RESTART);
      ssag_pkg::C_MORE:     cond_true = (idx_q < cnt_q);
      ssag_pkg::C_BUSY:     cond_true = busy;
      ssag_pkg::C_OUT_FULL: cond_true = out_full;
      default:              cond_true = 1'b1;
    endcase
    pc_d = cond_true ? ctl.target : pc_q + 1'b1;
  end

  // decision
  always_comb begin
    keep     = ~(found_q && (LW'(near_q) < LW'(limit_q)));
    last     = (cnt_q == CNTW'(SLOTS - 1));
    near_ext = EW'(near_q);
    sat      = near_ext > EW'(ssag_pkg::NEAR_ALL);
    near_field = (!found_q || sat) ? ssag_pkg::NEAR_ALL : near_ext[ssag_pkg::NEAR_W-1:0];
    cnt_d  = cnt_q;
    base_d = base_q;
    status = ssag_pkg::ST_RESTART;
    if (do_rst) begin
      cnt_d  = '0;
      base_d = '0;
    end else if (do_dec) begin
      if (!keep) begin
        status = ssag_pkg::ST_DISCARD;
      end else if (last) begin
        status = ssag_pkg::ST_COMPLETE;
      end else begin
        status = ssag_pkg::ST_STORED;
        cnt_d  = cnt_q + 1'b1;
        if (int'(cnt_d) == int'(base_q) + GROUP_SIZE) begin
          base_d = cnt_d;
        end
      end
    end
    cnt_wide = XW'(cnt_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= ssag_pkg::P_FETCH;
      cnt_q       <= '0;
      base_q      <= '0;
      limit_q     <= ssag_pkg::LIMIT_RESET;
      found_q     <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q     <= pc_d;
      cnt_q    <= cnt_d;
      base_q   <= base_d;
      rd_vld_q <= rd_en;
      if (cfg_valid_i) begin
        limit_q <= 32'(cfg_data_i) * 32'(cfg_data_i);
      end
      if (ctl.act.init) begin
        found_q <= 1'b0;
      end else if (d_vld) begin
        found_q <= 1'b1;
      end
      if (do_dec || do_rst) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= in_data_i.command;
      smp_q[0] <= axis_val(in_data_i.x);
      smp_q[1] <= axis_val(in_data_i.y);
      smp_q[2] <= axis_val(in_data_i.z);
    end
    if (ctl.act.init) begin
      idx_q <= base_q;
    end else if (rd_en) begin
      idx_q <= idx_q + 1'b1;
    end
    if (d_vld && (!found_q || d_val < near_q)) begin
      near_q <= d_val;
    end
    if (do_dec || do_rst) begin
      out_q.status          <= status;
      out_q.stored_count    <= cnt_wide[6:0];
      out_q.nearest_squared <= do_rst ? '0 : near_field;
    end
  end

  // sample memory
  always_ff @(posedge clk_i) begin
    if (do_dec && keep) begin
      mem[cnt_q] <= smp_q;
    end
    if (rd_en) begin
      rd_data_q <= mem[idx_q];
    end
  end

  ssag_dist #(
    .AXIS_BITS(AXIS_BITS)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rd_vld_q),
    .smp_i  (smp_q),
    .ent_i  (rd_data_q),
    .vld_o  (d_vld),
    .busy_o (d_busy),
    .dist_o (d_val)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) < SLOTS)
    else $error("sample count out of range");

  a_group_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q <= cnt_q) && (int'(cnt_q) - int'(base_q) < GROUP_SIZE))
    else $error("group base inconsistent with count");

  a_read_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (idx_q >= base_q) && (idx_q < cnt_q))
    else $error("read outside current group");

  a_decide_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_dec |-> !busy)
    else $error("decision taken while distance pipe busy");

  a_result_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_dec || do_rst) |=> !ctl.act.decide && !ctl.act.restart)
    else $error("more than one result for an item");
`endif

endmodule
